[sv/mtms_pkg.sv]
// shared types and constants for the masked temporal median select block
`timescale 1ns / 1ps
package mtms_pkg;

  // default number of frames carried per pixel position
  localparam int MAX_FRAMES_DEF = 5;

  // field widths
  localparam int PIX_W      = 24;
  localparam int COLOR_W    = 8;
  localparam int LABEL_W    = 8;
  localparam int FRAME_W    = 3;
  localparam int CNT_W      = 4;
  localparam int OUT_TDATA_W = 32;

  // configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // reset value of the frame count register
  localparam logic [FRAME_W-1:0] FRAMES_RST = 3'd5;

  // register indexes
  typedef enum logic [1:0] {
    REG_SEL_EN   = 2'd0,
    REG_TARGET   = 2'd1,
    REG_FALLBACK = 2'd2,
    REG_FRAMES   = 2'd3
  } reg_idx_e;

  // register contents handed to the datapath
  typedef struct packed {
    logic               sel_en;
    logic [LABEL_W-1:0] target;
    logic [FRAME_W-1:0] fallback;
    logic [FRAME_W-1:0] frames;
  } cfg_t;

  // per-item control that travels down the pipeline
  typedef struct packed {
    logic               bypass;
    logic [FRAME_W-1:0] fb_idx;
  } ctrl_t;

endpackage

[sv/masked_temporal_median_select.sv]
// top level of the masked temporal median select block
//
//  channel   dir  transfer when                 contents
//  s_axis    in   s_axis_tvalid_i & tready_o    frame pixels and mask label
//  m_axis    out  m_axis_tvalid_o & tready_i    selected pixel and its frame
//  apb       in   psel & penable & pwrite       four control registers
//
// one pixel position per cycle unless the output stalls; an item passes the registered stages
// capture, pairwise green compare, rank count, frame pick and output register, in that order
// reset clears the valid bits and loads the register defaults, frames in use 5
// a stall on the output freezes every stage together, input ready follows it
`timescale 1ns / 1ps
module masked_temporal_median_select #(
  parameter int MAX_FRAMES = mtms_pkg::MAX_FRAMES_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // frame0_pixel .. frame(n-1)_pixel, 24 bits each, then mask_label, 8 bits
  input  logic [MAX_FRAMES*mtms_pkg::PIX_W+mtms_pkg::LABEL_W-1:0] s_axis_tdata_i,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // out_blue 7:0, out_green 15:8, out_red 23:16, source_frame 26:24, zero fill
  output logic [mtms_pkg::OUT_TDATA_W-1:0]       m_axis_tdata_o,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mtms_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [mtms_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [mtms_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready
);

  localparam int PIXS_W = MAX_FRAMES * mtms_pkg::PIX_W;

  mtms_pkg::cfg_t        cfg;
  mtms_pkg::ctrl_t       ctrl;
  logic                  en;
  logic                  rank_valid;
  logic [PIXS_W-1:0]     rank_pix;
  logic [MAX_FRAMES-1:0] rank_cond;

  // pipeline advances whenever the output register is free or being drained
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  mtms_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mtms_rank #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_rank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg),
    .valid_i (s_axis_tvalid_i),
    .pix_i   (s_axis_tdata_i[PIXS_W-1:0]),
    .label_i (s_axis_tdata_i[PIXS_W +: mtms_pkg::LABEL_W]),
    .valid_o (rank_valid),
    .pix_o   (rank_pix),
    .cond_o  (rank_cond),
    .ctrl_o  (ctrl)
  );

  mtms_select #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rank_valid),
    .pix_i   (rank_pix),
    .cond_i  (rank_cond),
    .ctrl_i  (ctrl),
    .valid_o (m_axis_tvalid_o),
    .data_o  (m_axis_tdata_o)
  );

endmodule

[sv/mtms_cfg.sv]
// apb register file for the masked temporal median select block
`timescale 1ns / 1ps
module mtms_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mtms_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mtms_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mtms_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output mtms_pkg::cfg_t                      cfg_o
);

  mtms_pkg::cfg_t     cfg_q, cfg_d;
  mtms_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = mtms_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        mtms_pkg::REG_SEL_EN:   cfg_d.sel_en   = pwdata[0];
        mtms_pkg::REG_TARGET:   cfg_d.target   = pwdata[mtms_pkg::LABEL_W-1:0];
        mtms_pkg::REG_FALLBACK: cfg_d.fallback = pwdata[mtms_pkg::FRAME_W-1:0];
        mtms_pkg::REG_FRAMES:   cfg_d.frames   = pwdata[mtms_pkg::FRAME_W-1:0];
        default:                cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sel_en   <= 1'b0;
      cfg_q.target   <= '0;
      cfg_q.fallback <= '0;
      cfg_q.frames   <= mtms_pkg::FRAMES_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      mtms_pkg::REG_SEL_EN:   prdata[0] = cfg_q.sel_en;
      mtms_pkg::REG_TARGET:   prdata[mtms_pkg::LABEL_W-1:0] = cfg_q.target;
      mtms_pkg::REG_FALLBACK: prdata[mtms_pkg::FRAME_W-1:0] = cfg_q.fallback;
      mtms_pkg::REG_FRAMES:   prdata[mtms_pkg::FRAME_W-1:0] = cfg_q.frames;
      default:                prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[sv/mtms_rank.sv]
// capture, pairwise compare and rank stages of the median pipeline
`timescale 1ns / 1ps
module mtms_rank #(
  parameter int MAX_FRAMES = mtms_pkg::MAX_FRAMES_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  mtms_pkg::cfg_t                         cfg_i,
  input  logic                                   valid_i,
  input  logic [MAX_FRAMES*mtms_pkg::PIX_W-1:0]  pix_i,
  input  logic [mtms_pkg::LABEL_W-1:0]           label_i,
  output logic                                   valid_o,
  output logic [MAX_FRAMES*mtms_pkg::PIX_W-1:0]  pix_o,
  output logic [MAX_FRAMES-1:0]                  cond_o,
  output mtms_pkg::ctrl_t                        ctrl_o
);

  localparam int PW = mtms_pkg::PIX_W;
  localparam int CW = mtms_pkg::CNT_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAMES);

  // stage 1: capture item and per-item control
  logic                          v1_q;
  logic [MAX_FRAMES*PW-1:0]      pix1_q;
  logic [MAX_FRAMES-1:0]         act1_q, act1_d;
  logic [CW-1:0]                 half1_q, half1_d;
  mtms_pkg::ctrl_t               ctrl1_q, ctrl1_d;
  logic [CW-1:0]                 n_cnt, f_cnt;

  always_comb begin
    f_cnt = CW'(cfg_i.frames);
    if (f_cnt == '0) begin
      n_cnt = CW'(1);
    end else if (f_cnt > MAX_CNT) begin
      n_cnt = MAX_CNT;
    end else begin
      n_cnt = f_cnt;
    end
    half1_d = n_cnt >> 1;
    for (int j = 0; j < MAX_FRAMES; j++) begin
      act1_d[j] = CW'(j) < n_cnt;
    end
    ctrl1_d.bypass = cfg_i.sel_en && (label_i != cfg_i.target);
    if (CW'(cfg_i.fallback) >= n_cnt) begin
      ctrl1_d.fb_idx = mtms_pkg::FRAME_W'(n_cnt - CW'(1));
    end else begin
      ctrl1_d.fb_idx = cfg_i.fallback;
    end
  end

  // stage 2: pairwise green compares
  logic                          v2_q;
  logic [MAX_FRAMES*PW-1:0]      pix2_q;
  logic [MAX_FRAMES-1:0]         act2_q;
  logic [CW-1:0]                 half2_q;
  mtms_pkg::ctrl_t               ctrl2_q;
  logic [MAX_FRAMES-1:0]         lt2_q [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]         le2_q [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]         lt2_d [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]         le2_d [MAX_FRAMES];
  logic [mtms_pkg::COLOR_W-1:0]  grn [MAX_FRAMES];

  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      grn[i] = pix1_q[i*PW+8 +: mtms_pkg::COLOR_W];
    end
    for (int i = 0; i < MAX_FRAMES; i++) begin
      for (int j = 0; j < MAX_FRAMES; j++) begin
        lt2_d[i][j] = act1_q[j] && (grn[j] <  grn[i]);
        le2_d[i][j] = act1_q[j] && (grn[j] <= grn[i]);
      end
    end
  end

  // stage 3: rank counts, a frame qualifies when the median slot falls in its run
  logic                          v3_q;
  logic [MAX_FRAMES*PW-1:0]      pix3_q;
  logic [MAX_FRAMES-1:0]         cond3_q, cond3_d;
  mtms_pkg::ctrl_t               ctrl3_q;
  logic [CW-1:0]                 lt_cnt [MAX_FRAMES];
  logic [CW-1:0]                 le_cnt [MAX_FRAMES];

  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      lt_cnt[i] = '0;
      le_cnt[i] = '0;
      for (int j = 0; j < MAX_FRAMES; j++) begin
        lt_cnt[i] = lt_cnt[i] + CW'(lt2_q[i][j]);
        le_cnt[i] = le_cnt[i] + CW'(le2_q[i][j]);
      end
      cond3_d[i] = act2_q[i] && (lt_cnt[i] <= half2_q) && (le_cnt[i] > half2_q);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // payload, held while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix1_q  <= pix_i;
      act1_q  <= act1_d;
      half1_q <= half1_d;
      ctrl1_q <= ctrl1_d;
      pix2_q  <= pix1_q;
      act2_q  <= act1_q;
      half2_q <= half1_q;
      ctrl2_q <= ctrl1_q;
      lt2_q   <= lt2_d;
      le2_q   <= le2_d;
      pix3_q  <= pix2_q;
      cond3_q <= cond3_d;
      ctrl3_q <= ctrl2_q;
    end
  end

  assign valid_o = v3_q;
  assign pix_o   = pix3_q;
  assign cond_o  = cond3_q;
  assign ctrl_o  = ctrl3_q;

endmodule

[sv/mtms_select.sv]
// frame pick and output register of the median pipeline
`timescale 1ns / 1ps
module mtms_select #(
  parameter int MAX_FRAMES = mtms_pkg::MAX_FRAMES_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [MAX_FRAMES*mtms_pkg::PIX_W-1:0]  pix_i,
  input  logic [MAX_FRAMES-1:0]                  cond_i,
  input  mtms_pkg::ctrl_t                        ctrl_i,
  output logic                                   valid_o,
  output logic [mtms_pkg::OUT_TDATA_W-1:0]       data_o
);

  localparam int PW = mtms_pkg::PIX_W;
  localparam int FW = mtms_pkg::FRAME_W;

  logic [FW-1:0]                   med_idx, sel_idx;
  logic [PW-1:0]                   sel_pix;
  logic                            vo_q;
  logic [mtms_pkg::OUT_TDATA_W-1:0] data_q, data_d;

  // lowest qualifying frame wins, fallback overrides in selective mode when the label is not the target
  always_comb begin
    med_idx = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (cond_i[i]) begin
        med_idx = FW'(i);
      end
    end
    sel_idx = ctrl_i.bypass ? ctrl_i.fb_idx : med_idx;
    sel_pix = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (sel_idx == FW'(i)) begin
        sel_pix = pix_i[i*PW +: PW];
      end
    end
    data_d = {{(mtms_pkg::OUT_TDATA_W - PW - FW){1'b0}}, sel_idx, sel_pix};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = vo_q;
  assign data_o  = data_q;

endmodule
